FILE: sv/csvp_pkg.sv
// csvp_pkg: shared types and constants of the csv record and field parser
package csvp_pkg;

    localparam int CHAR_BITS = 16;

    localparam logic [CHAR_BITS-1:0] QUOTE_CHAR = CHAR_BITS'(16'h0022);
    localparam logic [CHAR_BITS-1:0] LF_CHAR    = CHAR_BITS'(16'h000A);
    localparam logic [CHAR_BITS-1:0] CR_CHAR    = CHAR_BITS'(16'h000D);
    localparam logic [CHAR_BITS-1:0] SEP_RESET  = CHAR_BITS'(16'h002C);

    // one classified code unit, as passed from front to back
    typedef struct packed {
        logic [CHAR_BITS-1:0] ch;
        logic                 last;
        logic                 is_quote;
        logic                 is_cr;
        logic                 is_lf;
        logic                 is_sep;
    } csvp_item_t;

    // parse mode, one-hot
    typedef enum logic [2:0] {
        MODE_PLAIN   = 3'b001,
        MODE_QUOTED  = 3'b010,
        MODE_PENDING = 3'b100
    } csvp_mode_t;

endpackage

FILE: sv/csvp_front.sv
// csvp_front: input stage that holds the separator and classifies code units
module csvp_front
    import csvp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 separator_we,
    input  logic [CHAR_BITS-1:0] separator,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [CHAR_BITS-1:0] in_char,
    input  logic                 last_of_input,
    output logic                 item_valid,
    input  logic                 item_ready,
    output csvp_item_t           item
);

    logic [CHAR_BITS-1:0] sep_reg;
    logic                 valid_reg;
    logic                 valid_next;
    csvp_item_t           item_reg;
    csvp_item_t           item_next;

    // separator register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sep_reg <= SEP_RESET;
        end
        else if (separator_we)
        begin
            sep_reg <= separator;
        end
    end

    // classify the incoming code unit
    always_comb
    begin
        item_next.ch       = in_char;
        item_next.last     = last_of_input;
        item_next.is_quote = (in_char == QUOTE_CHAR);
        item_next.is_cr    = (in_char == CR_CHAR);
        item_next.is_lf    = (in_char == LF_CHAR);
        item_next.is_sep   = (in_char == sep_reg);
    end

    assign in_ready = !valid_reg || item_ready;

    // stage valid
    always_comb
    begin
        if (in_ready)
        begin
            valid_next = in_valid;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= item_next;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

FILE: sv/csvp_queue.sv
// csvp_queue: two-entry queue between the classifying front and the parsing back
module csvp_queue
    import csvp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push_valid,
    output logic       push_ready,
    input  csvp_item_t push_item,
    output logic       pop_valid,
    input  logic       pop_ready,
    output csvp_item_t pop_item
);

    csvp_item_t entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;
    logic       pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_item   = entry_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    // count stays within depth
    assert property (@(posedge clk) disable iff (!rst_n) count_reg != 2'd3)
        else $error("queue count out of range");

endmodule

FILE: sv/csvp_back.sv
// csvp_back: quote, field and record state machine with the output register
module csvp_back
    import csvp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  csvp_item_t           item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [CHAR_BITS-1:0] out_char,
    output logic                 char_valid,
    output logic                 field_end,
    output logic                 record_end,
    output logic                 record_empty
);

    csvp_mode_t           mode_reg;
    csvp_mode_t           mode_next;
    logic                 after_cr_reg;
    logic                 after_cr_next;
    logic                 has_text_reg;
    logic                 has_text_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [CHAR_BITS-1:0] char_reg;
    logic                 char_valid_reg;
    logic                 field_end_reg;
    logic                 record_end_reg;
    logic                 record_empty_reg;

    logic                 pop;
    logic                 plain;
    logic                 have;
    logic [CHAR_BITS-1:0] o_char;
    logic                 o_valid;
    logic                 o_field;
    logic                 o_rec;
    logic                 o_empty;

    assign item_ready = !out_valid_reg || out_ready;
    assign pop        = item_valid && item_ready;

    // parse one classified unit
    always_comb
    begin
        mode_next     = mode_reg;
        after_cr_next = 1'b0;
        has_text_next = has_text_reg;
        plain         = 1'b0;
        have          = 1'b0;
        o_char        = '0;
        o_valid       = 1'b0;
        o_field       = 1'b0;
        o_rec         = 1'b0;
        o_empty       = 1'b0;

        unique case (mode_reg)
            MODE_QUOTED:
            begin
                has_text_next = 1'b1;
                if (item.is_quote)
                begin
                    mode_next = MODE_PENDING;
                end
                else
                begin
                    o_char  = item.ch;
                    o_valid = 1'b1;
                    have    = 1'b1;
                end
            end
            MODE_PENDING:
            begin
                has_text_next = 1'b1;
                if (item.is_quote)
                begin
                    mode_next = MODE_QUOTED;
                    o_char    = item.ch;
                    o_valid   = 1'b1;
                    have      = 1'b1;
                end
                else
                begin
                    mode_next = MODE_PLAIN;
                    plain     = 1'b1;
                end
            end
            default:
            begin
                plain = 1'b1;
            end
        endcase

        // unquoted handling: record end wins over separator, separator over quote
        if (plain)
        begin
            priority if (item.is_lf || item.is_cr)
            begin
                if (!(item.is_lf && after_cr_reg))
                begin
                    o_rec         = 1'b1;
                    o_empty       = !has_text_next;
                    have          = 1'b1;
                    has_text_next = 1'b0;
                    after_cr_next = item.is_cr;
                end
            end
            else if (item.is_sep)
            begin
                has_text_next = 1'b1;
                o_field       = 1'b1;
                have          = 1'b1;
            end
            else if (item.is_quote)
            begin
                has_text_next = 1'b1;
                mode_next     = MODE_QUOTED;
            end
            else
            begin
                has_text_next = 1'b1;
                o_char        = item.ch;
                o_valid       = 1'b1;
                have          = 1'b1;
            end
        end

        // end of input flushes a pending record and clears state
        if (item.last)
        begin
            if (has_text_next && !o_rec)
            begin
                o_rec   = 1'b1;
                o_empty = 1'b0;
                have    = 1'b1;
            end
            mode_next     = MODE_PLAIN;
            after_cr_next = 1'b0;
            has_text_next = 1'b0;
        end
    end

    // output valid
    always_comb
    begin
        if (item_ready)
        begin
            out_valid_next = pop && have;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // parser state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_PLAIN;
            after_cr_reg  <= 1'b0;
            has_text_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (pop)
            begin
                mode_reg     <= mode_next;
                after_cr_reg <= after_cr_next;
                has_text_reg <= has_text_next;
            end
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (pop && have)
        begin
            char_reg         <= o_char;
            char_valid_reg   <= o_valid;
            field_end_reg    <= o_field;
            record_end_reg   <= o_rec;
            record_empty_reg <= o_rec && o_empty;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_char     = char_reg;
    assign char_valid   = char_valid_reg;
    assign field_end    = field_end_reg;
    assign record_end   = record_end_reg;
    assign record_empty = record_empty_reg;

    // empty record carries no content and always ends the record
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && record_empty_reg |-> record_end_reg && !char_valid_reg
            && !field_end_reg)
        else $error("empty record flags inconsistent");

    // a result never carries both a character and a separator
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(char_valid_reg && field_end_reg))
        else $error("char and field end together");

    // a pending cr is only ever held in unquoted mode with no record text
    assert property (@(posedge clk) disable iff (!rst_n)
        after_cr_reg |-> mode_reg == MODE_PLAIN && !has_text_reg)
        else $error("after cr outside unquoted empty record");

    // a record end leaves the record empty
    assert property (@(posedge clk) disable iff (!rst_n)
        pop && have && o_rec |=> !has_text_reg)
        else $error("record text not cleared after record end");

endmodule

FILE: sv/csv_record_field_parser.sv
// csv_record_field_parser: top level, csv splitter with front, queue and back
// path: a result is registered in the front stage, a queue entry and the back output register
// throughput: one code unit per cycle, except while a waiting result is held by a low out_ready
// units that give no result (quote marks, swallowed lf) are consumed and show nothing
// the output register and the two-entry queue let input continue while a result waits
// reset: rst_n clears all valid and parser state at once; separator returns to comma
module csv_record_field_parser
    import csvp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 separator_we,
    input  logic [CHAR_BITS-1:0] separator,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [CHAR_BITS-1:0] in_char,
    input  logic                 last_of_input,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [CHAR_BITS-1:0] out_char,
    output logic                 char_valid,
    output logic                 field_end,
    output logic                 record_end,
    output logic                 record_empty
);

    logic       front_valid;
    logic       front_ready;
    csvp_item_t front_item;
    logic       back_valid;
    logic       back_ready;
    csvp_item_t back_item;

    // classify
    csvp_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .separator_we  (separator_we),
        .separator     (separator),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .in_char       (in_char),
        .last_of_input (last_of_input),
        .item_valid    (front_valid),
        .item_ready    (front_ready),
        .item          (front_item)
    );

    // decoupling queue
    csvp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_item  (front_item),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready),
        .pop_item   (back_item)
    );

    // parse and deliver
    csvp_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (back_valid),
        .item_ready   (back_ready),
        .item         (back_item),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_char     (out_char),
        .char_valid   (char_valid),
        .field_end    (field_end),
        .record_end   (record_end),
        .record_empty (record_empty)
    );

endmodule
